FILE: rtl/spsag_pkg.sv
// ----------------------------------------------------------------------------
// spsag_pkg
// Shared types and constants for the symmetric pad stick address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package spsag_pkg;

  // Field widths
  localparam int unsigned CfgWidth   = 24;
  localparam int unsigned PosWidth   = 24;
  localparam int unsigned StickBits  = 20;
  localparam int unsigned LaneBits   = 4;
  localparam int unsigned CfgIdxBits = 2;

  // Divider widths: the modulus is twice the source length
  localparam int unsigned DvdWidth   = 24;
  localparam int unsigned DvsWidth   = 25;
  localparam int unsigned DivSteps   = DvdWidth;
  localparam int unsigned DivCntBits = $clog2(DivSteps);

  // Elements per stick (a power of two, so the split is a shift and a mask)
  localparam int unsigned StickWidth = 16;
  localparam int unsigned StickShift = $clog2(StickWidth);

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CfgSourceLength = 2'd0,
    CfgPaddedLength = 2'd1,
    CfgPadBefore    = 2'd2
  } cfg_reg_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic start_mod;
    logic capture_mod;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/spsag_div.sv
// ----------------------------------------------------------------------------
// spsag_div
// Restoring divider, one quotient bit per cycle; computes the remainder of
// the logical index by the reflection period.
// ----------------------------------------------------------------------------
`default_nettype none

module spsag_div
  import spsag_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DvdWidth-1:0] dividend_i,
  input  logic [DvsWidth-1:0] divisor_i,
  output logic [DvsWidth-1:0] remainder_o,
  output logic                done_o
);

  logic [DvdWidth-1:0]   dvd_q, dvd_d;
  logic [DvsWidth-1:0]   rem_q, rem_d;
  logic [DvsWidth-1:0]   dvs_q;
  logic [DivCntBits-1:0] cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  logic [DvsWidth:0]     trial;
  logic                  ge;

  // One restoring step: shift in next dividend bit, subtract if it fits
  assign trial = {rem_q, dvd_q[DvdWidth-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DvsWidth'(trial - {1'b0, dvs_q}) : DvsWidth'(trial);
      dvd_d = {dvd_q[DvdWidth-2:0], ge};
      cnt_d = cnt_q + DivCntBits'(1);
      if (cnt_q == DivCntBits'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

`default_nettype wire

FILE: rtl/spsag_datapath.sv
// ----------------------------------------------------------------------------
// spsag_datapath
// Configuration registers, index arithmetic, stick cache and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spsag_datapath
  import spsag_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]   cfg_data_i,
  // input payload
  input  logic [PosWidth-1:0]   out_position_i,
  // controller link
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  // output channel
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic                  out_write_zero_o,
  output logic [StickBits-1:0]  out_src_stick_o,
  output logic [LaneBits-1:0]   out_src_lane_o,
  output logic                  out_fetch_stick_o,
  output logic                  out_release_old_o
);

  // Configuration registers
  logic [CfgWidth-1:0] src_len_q, pad_len_q, pad_before_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_len_q    <= '0;
      pad_len_q    <= '0;
      pad_before_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgSourceLength: src_len_q    <= cfg_data_i;
        CfgPaddedLength: pad_len_q    <= cfg_data_i;
        CfgPadBefore:    pad_before_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Item registers
  logic [PosWidth-1:0] pos_q;
  logic                zero_q, zero_d;
  logic                neg_q;
  logic [DvsWidth-1:0] r_q;

  logic [PosWidth:0]   diff;
  logic                neg;
  logic [DvdWidth-1:0] mag;
  logic [DvsWidth-1:0] period;

  // Logical index relative to the source start, as sign and magnitude
  assign diff   = {1'b0, pos_q} - {1'b0, pad_before_q};
  assign neg    = diff[PosWidth];
  assign mag    = neg ? DvdWidth'(-diff) : diff[DvdWidth-1:0];
  assign period = {src_len_q, 1'b0};
  assign zero_d = (pos_q >= pad_len_q) || (src_len_q == '0);

  // Period divider
  logic [DvsWidth-1:0] div_rem;
  logic                div_done;
  logic [DvsWidth-1:0] r_adj;
  logic [DvdWidth-1:0] src_idx;

  // Fold the remainder of a negative index back into [0, period)
  assign r_adj = (neg_q && (div_rem != '0)) ? DvsWidth'(period - div_rem) : div_rem;

  // Mirror the upper half of the period onto the source
  assign src_idx = (r_q < {1'b0, src_len_q}) ? r_q[DvdWidth-1:0]
                                             : DvdWidth'(period - DvsWidth'(1) - r_q);

  spsag_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.start_mod),
    .dividend_i  (mag),
    .divisor_i   (period),
    .remainder_o (div_rem),
    .done_o      (div_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      pos_q <= out_position_i;
    end
    if (cmd_i.start_mod) begin
      neg_q <= neg;
    end
    if (cmd_i.capture_mod) begin
      r_q <= r_adj;
    end
  end

  // Zero flag is evaluated in the setup cycle after the item lands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= 1'b0;
    end else if (cmd_i.load_item) begin
      zero_q <= 1'b0;
    end else begin
      zero_q <= zero_d;
    end
  end

  // Stick cache and miss logic
  logic [StickBits-1:0] held_stick_q;
  logic                 held_valid_q;
  logic [StickBits-1:0] stick;
  logic [LaneBits-1:0]  lane;
  logic                 miss;

  // Stick split by shift and mask
  assign stick = StickBits'(src_idx >> StickShift);
  assign lane  = LaneBits'(src_idx & DvdWidth'(StickWidth - 1));
  assign miss  = !held_valid_q || (held_stick_q != stick);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_stick_q <= '0;
      held_valid_q <= 1'b0;
    end else if (cmd_i.emit && !zero_q && miss) begin
      held_stick_q <= stick;
      held_valid_q <= 1'b1;
    end
  end

  // Output register
  logic                 out_valid_q;
  logic                 wz_q, fetch_q, rel_q;
  logic [StickBits-1:0] ostick_q;
  logic [LaneBits-1:0]  olane_q;
  logic                 out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      wz_q     <= zero_q;
      ostick_q <= zero_q ? '0 : stick;
      olane_q  <= zero_q ? '0 : lane;
      fetch_q  <= !zero_q && miss;
      rel_q    <= !zero_q && miss && held_valid_q;
    end
  end

  assign status_o.zero     = zero_d;
  assign status_o.div_done = div_done;
  assign status_o.out_free = out_free;

  assign out_valid_o       = out_valid_q;
  assign out_write_zero_o  = wz_q;
  assign out_src_stick_o   = ostick_q;
  assign out_src_lane_o    = olane_q;
  assign out_fetch_stick_o = fetch_q;
  assign out_release_old_o = rel_q;

endmodule

`default_nettype wire

FILE: rtl/spsag_ctrl.sv
// ----------------------------------------------------------------------------
// spsag_ctrl
// Sequencer: accept, setup, period modulo, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module spsag_ctrl
  import spsag_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StSetup  = 4'b0010,
    StModRun = 4'b0100,
    StEmit   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = StSetup;
        end
      end
      StSetup: begin
        if (status_i.zero) begin
          state_d = StEmit;
        end else begin
          cmd_o.start_mod = 1'b1;
          state_d         = StModRun;
        end
      end
      StModRun: begin
        if (status_i.div_done) begin
          cmd_o.capture_mod = 1'b1;
          state_d           = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

`default_nettype wire

FILE: rtl/symmetric_pad_stick_address_gen.sv
// ----------------------------------------------------------------------------
// symmetric_pad_stick_address_gen
// Maps a padded output index to a source stick and lane with symmetric,
// edge-repeating padding, and tracks a one-stick source cache.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------
//   cfg     | in        | cfg_we_i               | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i / in_stall_o| in_out_position_i
//   out     | out       | out_valid_o/out_stall_i| write_zero, stick, lane,
//           |           |                        | fetch, release
//
// One transaction at a time. With no output stall an item passes through
// accept, setup, 24 steps of the bit-serial period modulo plus its done
// strobe, capture and emit. The stick/lane split is a shift and a mask.
// Zero-result items skip the modulo. Reset clears configuration and the cache.
// The result sits in an output register, so a new item is accepted while the
// previous result is still stalled; the sequencer waits at emit if needed.
// ----------------------------------------------------------------------------
`default_nettype none

module symmetric_pad_stick_address_gen
  import spsag_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]   cfg_data_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PosWidth-1:0]   in_out_position_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  out_write_zero_o,
  output logic [StickBits-1:0]  out_src_stick_o,
  output logic [LaneBits-1:0]   out_src_lane_o,
  output logic                  out_fetch_stick_o,
  output logic                  out_release_old_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  spsag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spsag_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_position_i    (in_out_position_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .out_write_zero_o  (out_write_zero_o),
    .out_src_stick_o   (out_src_stick_o),
    .out_src_lane_o    (out_src_lane_o),
    .out_fetch_stick_o (out_fetch_stick_o),
    .out_release_old_o (out_release_old_o)
  );

endmodule

`default_nettype wire
